@@ rtl/pau_pkg.sv @@
`timescale 1ns / 1ps
// pau_pkg: shared constants, codes and types of the projected ADAM update block.
// No dependencies; imported by pau_mul, pau_dsu, projected_adam_update and pau_chk.
package pau_pkg;

	localparam int VEC_LEN   = 1024;
	localparam int IDX_W     = $clog2(VEC_LEN);
	localparam int DSU_OPW   = 64;               // div/sqrt operand width
	localparam int DSU_DVW   = 40;               // div/sqrt divisor / remainder width
	localparam int DSU_CNTW  = 7;
	localparam int MUL_W     = 33;               // signed multiplier operand width
	localparam logic [16:0] Q_ONE     = 17'd65536;
	localparam logic [31:0] DESC_LIM  = 32'h7FFF_FFFF;

	typedef enum logic [2:0] {
		RA_MODE  = 3'd0,
		RA_GAIN  = 3'd1,
		RA_NU    = 3'd2,
		RA_BETA1 = 3'd3,
		RA_BETA2 = 3'd4,
		RA_EPS   = 3'd5,
		RA_LOWER = 3'd6,
		RA_UPPER = 3'd7
	} reg_addr_t;

	localparam logic [2:0] MODE_ADAM_CONST = 3'd0;
	localparam logic [2:0] MODE_ADAM_DEC   = 3'd1;
	localparam logic [2:0] MODE_PLAIN_MU   = 3'd2;
	localparam logic [2:0] MODE_PLAIN_DEC  = 3'd3;

	localparam logic [1:0] CLAMP_IN = 2'd0;
	localparam logic [1:0] CLAMP_LO = 2'd1;
	localparam logic [1:0] CLAMP_HI = 2'd2;

	typedef enum logic [20:0] {
		ST_CLR    = 21'h000001,
		ST_IDLE   = 21'h000002,
		ST_LOAD   = 21'h000004,
		ST_STP_SQ = 21'h000008,
		ST_STP_DV = 21'h000010,
		ST_MA     = 21'h000020,
		ST_MB     = 21'h000040,
		ST_MC     = 21'h000080,
		ST_MD     = 21'h000100,
		ST_ME     = 21'h000200,
		ST_MF     = 21'h000400,
		ST_MG     = 21'h000800,
		ST_MH     = 21'h001000,
		ST_DV_M   = 21'h002000,
		ST_DV_V   = 21'h004000,
		ST_SQ_V   = 21'h008000,
		ST_DV_D   = 21'h010000,
		ST_APL    = 21'h020000,
		ST_FIN    = 21'h040000,
		ST_UP1    = 21'h080000,
		ST_UP2    = 21'h100000
	} state_t;

	typedef struct packed {
		logic                 start;
		logic                 is_sqrt;
		logic [DSU_OPW-1:0]   opnd;
		logic [DSU_DVW-1:0]   dvs;
	} dsu_req_t;

endpackage

@@ rtl/pau_ram.sv @@
`timescale 1ns / 1ps
// pau_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module pau_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/pau_mul.sv @@
`timescale 1ns / 1ps
// pau_mul: shared signed 33x33 multiplier with registered product.
// Depends on pau_pkg.
module pau_mul import pau_pkg::*; (
	input  logic                      clk,
	input  logic signed [MUL_W-1:0]   a,
	input  logic signed [MUL_W-1:0]   b,
	output logic signed [2*MUL_W-1:0] prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end
endmodule

@@ rtl/pau_dsu.sv @@
`timescale 1ns / 1ps
// pau_dsu: shared restoring divider / square root unit, one result bit per cycle.
// Depends on pau_pkg.
module pau_dsu import pau_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dsu_req_t           req,
	output logic               done,
	output logic [DSU_OPW-1:0] res
);
	logic [DSU_OPW-1:0]  sh_q, res_q;
	logic [DSU_DVW-1:0]  rem_q, dvs_q, cand, trial, rem_n;
	logic [DSU_CNTW-1:0] cnt_q;
	logic                sqrt_q, run_q, done_q, ge;

	always_comb begin
		if (sqrt_q) begin
			cand  = {rem_q[DSU_DVW-3:0], sh_q[DSU_OPW-1 -: 2]};
			trial = {res_q[DSU_DVW-3:0], 2'b01};
		end else begin
			cand  = {rem_q[DSU_DVW-2:0], sh_q[DSU_OPW-1]};
			trial = dvs_q;
		end
		ge    = (cand >= trial);
		rem_n = ge ? (cand - trial) : cand;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= req.is_sqrt ? DSU_CNTW'(DSU_OPW / 2) : DSU_CNTW'(DSU_OPW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DSU_CNTW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sh_q   <= req.opnd;
			dvs_q  <= req.dvs;
			sqrt_q <= req.is_sqrt;
			rem_q  <= '0;
			res_q  <= '0;
		end else if (run_q) begin
			sh_q  <= sqrt_q ? (sh_q << 2) : (sh_q << 1);
			rem_q <= rem_n;
			res_q <= {res_q[DSU_OPW-2:0], ge};
		end
	end

	assign done = done_q;
	assign res  = res_q;
endmodule

@@ rtl/projected_adam_update.sv @@
`timescale 1ns / 1ps
// projected_adam_update: top level, sequencer, config registers and moment stores.
// Depends on pau_pkg, pau_ram, pau_mul, pau_dsu.
//
//  channel | signals                              | transaction
//  --------+--------------------------------------+-------------------------------
//  s_*     | s_tvalid s_tready s_tdata s_tlast    | one element in (tvalid&tready)
//  m_*     | m_tvalid m_tready m_tdata m_tuser    | one updated element out
//          |  m_tlast                             |
//  apb     | psel penable pwrite paddr pwdata     | register write/read, pready=1
//          |  prdata pready                       |
//
// Sequencing: ADAM modes run three divisions and a square root per element on
//  the shared div/sqrt unit; plain modes need only the multiplier per element.
//  The first element of a pass adds the step-size rule: a square root then a
//  division in the decreasing modes, a division in mu-convex mode. The last
//  element of a pass adds the beta power update.
// Reset: after arst_n the moment stores are cleared, one entry a cycle, all
//  1024 entries, during which s_tready stays low; register writes work throughout.
// Stalls: one element at a time; s_tready is high only while idle. A finished
//  result waits in the output register while the next element is taken; the
//  sequencer holds in its output state while that register is still full.
module projected_adam_update import pau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// APB-style configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // [9:0] element_index, [41:10] gradient_value,
	                               // [73:42] control_value, [79:74] zero
	input  logic        s_tlast,   // last_element
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [31:0] new_control, [41:32] out_index, [47:42] zero
	output logic [1:0]  m_tuser,   // [1:0] clamp_status
	output logic        m_tlast    // pass_end
);
	// configuration registers
	logic [2:0]  mode_q;
	logic [30:0] gain_q, nu_q;
	logic [15:0] b1_q, b2_q, eps_q;
	logic [31:0] lo_q, hi_q;

	// persistent state
	logic [19:0] k_q;
	logic [16:0] bfp_q, bsp_q;
	logic [30:0] step_q;
	logic        pass_start_q;

	// per-element working registers
	state_t           state_q;
	logic [IDX_W-1:0] clr_q;
	logic [9:0]       idx_q;
	logic [31:0]      g_q, u_q, m_q, v_q, mnew_q, vnew_q, gsq_q, dm_q;
	logic             last_q, neg_q;
	logic signed [2*MUL_W-1:0] acc_q;
	logic [16:0]      c1_q, c2_q;
	logic [47:0]      mhat_q;

	// output register
	logic        ov_q, ol_q;
	logic [31:0] oc_q;
	logic [9:0]  oi_q;
	logic [1:0]  os_q;

	// shared units
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*MUL_W-1:0] prod_q, mac;
	dsu_req_t           dsu_req;
	logic               dsu_done;
	logic [DSU_OPW-1:0] dsu_res;

	// moment stores
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [31:0]      m_wdata, v_wdata, m_rd, v_rd;

	// helpers
	logic        adam, out_free, ov_set, cfg_we;
	logic [31:0] ag, mag;
	logic [20:0] k1;
	logic [36:0] mu_den;
	logic [32:0] den;
	logic [45:0] delta;
	logic signed [47:0] nv, lo_x, hi_x;
	logic [31:0] nv_c;
	logic [1:0]  nv_s;

	assign adam     = (mode_q == MODE_ADAM_CONST) || (mode_q == MODE_ADAM_DEC);
	assign ag       = g_q[31] ? 32'(-g_q) : g_q;
	assign mag      = mnew_q[31] ? 32'(-mnew_q) : mnew_q;
	assign k1       = {1'b0, k_q} + 21'd1;
	assign mu_den   = {k1, 16'b0} + {6'b0, nu_q};
	assign mac      = acc_q + prod_q;
	assign out_free = !ov_q || m_tready;
	assign ov_set   = (state_q == ST_FIN) && out_free;
	assign cfg_we   = psel && penable && pwrite && pready;

	always_comb begin
		den = {1'b0, dsu_res[31:0]} + {17'b0, eps_q};
		if (den == '0) begin
			den = 33'd1;
		end
	end

	// final update: delta = step*|descent| >> 16, then clamp
	always_comb begin
		delta = prod_q[61:16];
		lo_x  = {{16{lo_q[31]}}, lo_q};
		hi_x  = {{16{hi_q[31]}}, hi_q};
		nv    = neg_q ? ({{16{u_q[31]}}, u_q} + {2'b0, delta})
		              : ({{16{u_q[31]}}, u_q} - {2'b0, delta});
		if (nv < lo_x) begin
			nv_c = lo_q;
			nv_s = CLAMP_LO;
		end else if (nv > hi_x) begin
			nv_c = hi_q;
			nv_s = CLAMP_HI;
		end else begin
			nv_c = nv[31:0];
			nv_s = CLAMP_IN;
		end
	end

	// multiplier operands and div/sqrt requests by sequencer state
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		dsu_req = '0;
		unique case (state_q)
			ST_LOAD: begin
				if (pass_start_q && (mode_q == MODE_ADAM_DEC || mode_q == MODE_PLAIN_DEC)) begin
					dsu_req.start   = 1'b1;
					dsu_req.is_sqrt = 1'b1;
					dsu_req.opnd    = {11'b0, k1, 32'b0};
				end else if (pass_start_q && mode_q == MODE_PLAIN_MU) begin
					dsu_req.start = 1'b1;
					dsu_req.opnd  = {17'b0, gain_q, 16'b0};
					dsu_req.dvs   = {3'b0, mu_den};
				end
			end
			ST_STP_SQ: begin
				dsu_req.start = dsu_done;
				dsu_req.opnd  = {17'b0, gain_q, 16'b0};
				dsu_req.dvs   = {13'b0, dsu_res[26:0]};
			end
			ST_MA: begin
				mul_a = $signed({17'b0, b1_q});
				mul_b = $signed({m_q[31], m_q});
			end
			ST_MB: begin
				mul_a = $signed({16'b0, Q_ONE - {1'b0, b1_q}});
				mul_b = $signed({g_q[31], g_q});
			end
			ST_MC: begin
				mul_a = $signed({1'b0, ag});
				mul_b = $signed({1'b0, ag});
			end
			ST_MD: begin
				mul_a = $signed({17'b0, b2_q});
				mul_b = $signed({1'b0, v_q});
			end
			ST_ME: begin
				mul_a = $signed({16'b0, Q_ONE - {1'b0, b2_q}});
				mul_b = $signed({1'b0, gsq_q});
			end
			ST_MF: begin
				mul_a = $signed({16'b0, bfp_q});
				mul_b = $signed({17'b0, b1_q});
			end
			ST_FIN: begin
				// keep step*|descent| in the product while the output is blocked
				if (out_free) begin
					mul_a = $signed({16'b0, bfp_q});
					mul_b = $signed({17'b0, b1_q});
				end else begin
					mul_a = $signed({2'b0, step_q});
					mul_b = $signed({1'b0, dm_q});
				end
			end
			ST_MG, ST_UP1: begin
				mul_a = $signed({16'b0, bsp_q});
				mul_b = $signed({17'b0, b2_q});
			end
			ST_MH: begin
				dsu_req.start = 1'b1;
				dsu_req.opnd  = {16'b0, mag, 16'b0};
				dsu_req.dvs   = {23'b0, c1_q};
			end
			ST_DV_M: begin
				dsu_req.start = dsu_done;
				dsu_req.opnd  = {16'b0, vnew_q, 16'b0};
				dsu_req.dvs   = {23'b0, c2_q};
			end
			ST_DV_V: begin
				dsu_req.start   = dsu_done;
				dsu_req.is_sqrt = 1'b1;
				dsu_req.opnd    = {dsu_res[47:0], 16'b0};
			end
			ST_SQ_V: begin
				dsu_req.start = dsu_done;
				dsu_req.opnd  = {mhat_q, 16'b0};
				dsu_req.dvs   = {7'b0, den};
			end
			ST_APL: begin
				mul_a = $signed({2'b0, step_q});
				mul_b = $signed({1'b0, dm_q});
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_q        <= '0;
			k_q          <= '0;
			bfp_q        <= Q_ONE;
			bsp_q        <= Q_ONE;
			step_q       <= '0;
			pass_start_q <= 1'b1;
			ov_q         <= 1'b0;
		end else begin
			ov_q <= ov_set || (ov_q && !m_tready);
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(VEC_LEN - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (pass_start_q &&
					    (mode_q == MODE_ADAM_DEC || mode_q == MODE_PLAIN_DEC)) begin
						state_q <= ST_STP_SQ;
					end else if (pass_start_q && mode_q == MODE_PLAIN_MU) begin
						state_q <= ST_STP_DV;
					end else begin
						if (pass_start_q) begin
							step_q       <= gain_q;
							pass_start_q <= 1'b0;
						end
						state_q <= adam ? ST_MA : ST_APL;
					end
				end
				ST_STP_SQ: if (dsu_done) state_q <= ST_STP_DV;
				ST_STP_DV: begin
					if (dsu_done) begin
						step_q       <= dsu_res[30:0];
						pass_start_q <= 1'b0;
						state_q      <= adam ? ST_MA : ST_APL;
					end
				end
				ST_MA: state_q <= ST_MB;
				ST_MB: state_q <= ST_MC;
				ST_MC: state_q <= ST_MD;
				ST_MD: state_q <= ST_ME;
				ST_ME: state_q <= ST_MF;
				ST_MF: state_q <= ST_MG;
				ST_MG: state_q <= ST_MH;
				ST_MH: state_q <= ST_DV_M;
				ST_DV_M: if (dsu_done) state_q <= ST_DV_V;
				ST_DV_V: if (dsu_done) state_q <= ST_SQ_V;
				ST_SQ_V: if (dsu_done) state_q <= ST_DV_D;
				ST_DV_D: if (dsu_done) state_q <= ST_APL;
				ST_APL: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= last_q ? ST_UP1 : ST_IDLE;
					end
				end
				ST_UP1: begin
					bfp_q   <= prod_q[32:16];
					state_q <= ST_UP2;
				end
				ST_UP2: begin
					bsp_q        <= prod_q[32:16];
					k_q          <= k_q + 1'b1;
					pass_start_q <= 1'b1;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers (no reset)
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				idx_q  <= s_tdata[9:0];
				g_q    <= s_tdata[41:10];
				u_q    <= s_tdata[73:42];
				last_q <= s_tlast;
			end
			ST_LOAD: begin
				m_q   <= m_rd;
				v_q   <= v_rd;
				dm_q  <= ag;
				neg_q <= g_q[31];
			end
			ST_MB, ST_ME: acc_q <= prod_q;
			ST_MC: mnew_q <= mac[47:16];
			ST_MD: gsq_q <= (|prod_q[65:48]) ? 32'hFFFF_FFFF : prod_q[47:16];
			ST_MF: vnew_q <= mac[47:16];
			ST_MG: c1_q <= Q_ONE - prod_q[32:16];
			ST_MH: c2_q <= Q_ONE - prod_q[32:16];
			ST_DV_M: if (dsu_done) mhat_q <= dsu_res[47:0];
			ST_DV_D: begin
				if (dsu_done) begin
					dm_q  <= (dsu_res > {32'b0, DESC_LIM}) ? DESC_LIM : dsu_res[31:0];
					neg_q <= mnew_q[31];
				end
			end
			ST_FIN: begin
				if (out_free) begin
					oc_q <= nv_c;
					oi_q <= idx_q;
					os_q <= nv_s;
					ol_q <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ADAM_CONST;
			gain_q <= 31'd65536;
			nu_q   <= '0;
			b1_q   <= 16'd58982;
			b2_q   <= 16'd65470;
			eps_q  <= 16'd1;
			lo_q   <= 32'h8000_0000;
			hi_q   <= 32'h7FFF_FFFF;
		end else if (cfg_we) begin
			unique case (reg_addr_t'(paddr[4:2]))
				RA_MODE:  mode_q <= pwdata[2:0];
				RA_GAIN:  gain_q <= pwdata[30:0];
				RA_NU:    nu_q   <= pwdata[30:0];
				RA_BETA1: b1_q   <= pwdata[15:0];
				RA_BETA2: b2_q   <= pwdata[15:0];
				RA_EPS:   eps_q  <= pwdata[15:0];
				RA_LOWER: lo_q   <= pwdata;
				RA_UPPER: hi_q   <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_addr_t'(paddr[4:2]))
			RA_MODE:  prdata = {29'b0, mode_q};
			RA_GAIN:  prdata = {1'b0, gain_q};
			RA_NU:    prdata = {1'b0, nu_q};
			RA_BETA1: prdata = {16'b0, b1_q};
			RA_BETA2: prdata = {16'b0, b2_q};
			RA_EPS:   prdata = {16'b0, eps_q};
			RA_LOWER: prdata = lo_q;
			RA_UPPER: prdata = hi_q;
			default:  prdata = '0;
		endcase
	end
	assign pready = 1'b1;

	// moment stores: cleared after reset, written once per ADAM element
	assign ram_we    = (state_q == ST_CLR) || (state_q == ST_MH);
	assign ram_waddr = (state_q == ST_CLR) ? clr_q : idx_q[IDX_W-1:0];
	assign m_wdata   = (state_q == ST_CLR) ? '0 : mnew_q;
	assign v_wdata   = (state_q == ST_CLR) ? '0 : vnew_q;

	pau_ram #(.WIDTH(32), .DEPTH(VEC_LEN)) u_m_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(m_wdata),
		.raddr(s_tdata[IDX_W-1:0]), .rdata(m_rd)
	);

	pau_ram #(.WIDTH(32), .DEPTH(VEC_LEN)) u_v_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(v_wdata),
		.raddr(s_tdata[IDX_W-1:0]), .rdata(v_rd)
	);

	pau_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_q(prod_q));

	pau_dsu u_dsu (.clk(clk), .arst_n(arst_n), .req(dsu_req), .done(dsu_done), .res(dsu_res));

	// stream ports
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = ov_q;
	assign m_tdata  = {6'b0, oi_q, oc_q};
	assign m_tuser  = os_q;
	assign m_tlast  = ol_q;
endmodule

@@ rtl/pau_chk.sv @@
`timescale 1ns / 1ps
// pau_chk: port-level assertions for projected_adam_update, bound to the top level.
// Depends on pau_pkg.
module pau_chk import pau_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [1:0]  m_tuser
);
	// held result stays put while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output transaction changed under stall");

	// one element at a time: no accept on the cycle after an accept
	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == CLAMP_IN || m_tuser == CLAMP_LO || m_tuser == CLAMP_HI))
		else $error("bad clamp status");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[47:42] == 6'b0))
		else $error("tdata padding not zero");

	a_pready: assert property (@(posedge clk) pready)
		else $error("pready low");
endmodule

bind projected_adam_update pau_chk u_pau_chk (.*);
